@@ rtl/nthap_pkg.sv @@
`default_nettype none

package nthap_pkg;

  localparam int unsigned ScoreW = 14;
  localparam int unsigned TrendW = 15;
  localparam int unsigned TechW  = 3;
  localparam int unsigned DomW   = 3;
  localparam int unsigned ReasonW = 3;

  typedef logic [ScoreW-1:0]        score_t;
  typedef logic signed [TrendW-1:0] trend_t;
  typedef logic [TechW-1:0]         tech_t;
  typedef logic [DomW-1:0]          dom_t;
  typedef logic [ReasonW-1:0]       reason_t;

  // technique codes
  localparam tech_t TECH_NONE = 3'd0;
  localparam tech_t TECH_GNSS = 3'd1;
  localparam tech_t TECH_IMU  = 3'd2;
  localparam tech_t TECH_CAM  = 3'd3;
  localparam tech_t TECH_LDR  = 3'd4;
  localparam tech_t TECH_ACU  = 3'd5;
  localparam tech_t TECH_MAG  = 3'd6;
  localparam tech_t TECH_BARO = 3'd7;

  // domain codes
  localparam dom_t DOM_AIR  = 3'd0;
  localparam dom_t DOM_ROAD = 3'd1;
  localparam dom_t DOM_FLD  = 3'd2;
  localparam dom_t DOM_SEA  = 3'd3;
  localparam dom_t DOM_SUB  = 3'd4;

  // reason codes
  localparam reason_t RSN_BOOT   = 3'd0;
  localparam reason_t RSN_BELOW  = 3'd1;
  localparam reason_t RSN_HOLDB  = 3'd2;
  localparam reason_t RSN_SWITCH = 3'd3;
  localparam reason_t RSN_HOLD   = 3'd4;
  localparam reason_t RSN_BADTH  = 3'd5;

  // register indexes
  localparam logic CFG_ENTER = 1'b0;
  localparam logic CFG_EXIT  = 1'b1;

  localparam score_t ENTER_RST = 14'd6000;
  localparam score_t EXIT_RST  = 14'd3000;

  // fixed scores
  localparam score_t SC_ZERO      = 14'd0;
  localparam score_t SC_GNSS_OUTL = 14'd500;
  localparam score_t SC_IMU_NOFIX = 14'd9000;
  localparam score_t SC_IMU_RCNT  = 14'd6375;
  localparam score_t SC_IMU_PLAIN = 14'd7500;
  localparam score_t SC_MAG       = 14'd1500;

  localparam trend_t TR_OUTL  = -15'sd10000;
  localparam trend_t TR_GOOD  = 15'sd5000;
  localparam trend_t TR_FIX   = -15'sd2500;
  localparam trend_t TR_NOFIX = -15'sd7500;
  localparam trend_t TR_IMU_OK  = 15'sd0;
  localparam trend_t TR_IMU_BAD = -15'sd10000;

  // GNSS prior per domain; zero for submerged and unknown
  function automatic score_t gnss_prior(input dom_t d);
    score_t p;
    case (d)
      DOM_AIR, DOM_ROAD: p = 14'd9500;
      DOM_FLD:           p = 14'd7000;
      DOM_SEA:           p = 14'd8500;
      default:           p = SC_ZERO;
    endcase
    return p;
  endfunction

  // prior scaled by 0.55 (exact for every prior)
  function automatic score_t gnss_derated(input dom_t d);
    score_t p;
    case (d)
      DOM_AIR, DOM_ROAD: p = 14'd5225;
      DOM_FLD:           p = 14'd3850;
      DOM_SEA:           p = 14'd4675;
      default:           p = SC_ZERO;
    endcase
    return p;
  endfunction

  function automatic score_t baro_prior(input dom_t d);
    score_t p;
    case (d)
      DOM_AIR:         p = 14'd2000;
      DOM_SEA, DOM_SUB: p = 14'd2500;
      default:         p = SC_ZERO;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/nav_technique_hysteresis_arbiter.sv @@
`default_nettype none

// Navigation technique arbiter with hysteresis. One environment report is
// taken per clock (start high, busy is never raised) and its result leaves
// the four register stages on the out_ ports for exactly one cycle with
// out_valid high; the receiver cannot hold a result back, so there is no
// stall path. The stages are input capture, scoring, best-of-seven compare
// tree, and the bootstrap / hold / hysteresis decision.
// Sustained rate is one report per cycle. Scores are in units of 1/10000.
// Ties for the best score go to the lowest technique index; camera, lidar
// and acoustic always score zero. If enter_level is not above exit_level the
// result carries reason "bad thresholds", best technique and score of zero
// and keeps the current selection; the trends are reported regardless.
// The two threshold registers are written through cfg_we / cfg_index /
// cfg_wdata and should only change while no report is in flight.
module nav_technique_hysteresis_arbiter
  import nthap_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // command side
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [DomW-1:0]          in_domain,
  input  wire logic                     in_gnss_outlier,
  input  wire logic                     in_gnss_fix_ok,
  input  wire logic                     in_gnss_recent_accept,
  input  wire logic                     in_imu_healthy,
  input  wire logic [TechW-1:0]         in_current_technique,
  // result side
  output logic                          out_valid,
  output logic [TechW-1:0]              out_selected_technique,
  output logic [TechW-1:0]              out_best_technique,
  output logic [ScoreW-1:0]             out_best_score,
  output logic                          out_switched,
  output logic [ReasonW-1:0]            out_reason_code,
  output logic signed [TrendW-1:0]      out_gnss_trend,
  output logic signed [TrendW-1:0]      out_imu_trend,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [ScoreW-1:0]        cfg_wdata
);

  // ------------------------------------------------------------------
  // Threshold registers
  // ------------------------------------------------------------------
  score_t enter_r, exit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enter_r <= ENTER_RST;
      exit_r  <= EXIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTER: enter_r <= cfg_wdata;
        CFG_EXIT:  exit_r  <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // every cycle is open for a transfer
  assign busy = 1'b0;

  logic in_xfer;
  assign in_xfer = start && !busy;

  // ------------------------------------------------------------------
  // Stage 1: capture the report
  // ------------------------------------------------------------------
  logic  s1_vld_r;
  dom_t  s1_dom_r;
  logic  s1_outl_r, s1_fix_r, s1_rcnt_r, s1_imu_r;
  tech_t s1_cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= in_xfer;
  end

  always_ff @(posedge clk) begin
    s1_dom_r  <= in_domain;
    s1_outl_r <= in_gnss_outlier;
    s1_fix_r  <= in_gnss_fix_ok;
    s1_rcnt_r <= in_gnss_recent_accept;
    s1_imu_r  <= in_imu_healthy;
    s1_cur_r  <= in_current_technique;
  end

  // ------------------------------------------------------------------
  // Stage 2: per-technique scores, trends, threshold sanity
  // ------------------------------------------------------------------
  score_t sc_gnss_nxt, sc_imu_nxt, sc_baro_nxt;
  trend_t gtr_nxt, itr_nxt;
  logic   bad_nxt;

  always_comb begin
    // GNSS: zero prior dominates, then outlier, then fix / recent accept
    if (gnss_prior(s1_dom_r) == SC_ZERO) sc_gnss_nxt = SC_ZERO;
    else if (s1_outl_r)                  sc_gnss_nxt = SC_GNSS_OUTL;
    else if (!s1_fix_r)                  sc_gnss_nxt = SC_ZERO;
    else if (!s1_rcnt_r)                 sc_gnss_nxt = gnss_derated(s1_dom_r);
    else                                 sc_gnss_nxt = gnss_prior(s1_dom_r);

    // IMU scores higher when GNSS cannot be trusted
    if (!s1_imu_r)                     sc_imu_nxt = SC_ZERO;
    else if (s1_outl_r || !s1_fix_r)   sc_imu_nxt = SC_IMU_NOFIX;
    else if (s1_rcnt_r)                sc_imu_nxt = SC_IMU_RCNT;
    else                               sc_imu_nxt = SC_IMU_PLAIN;

    sc_baro_nxt = baro_prior(s1_dom_r);

    if (s1_outl_r)                   gtr_nxt = TR_OUTL;
    else if (s1_fix_r && s1_rcnt_r)  gtr_nxt = TR_GOOD;
    else if (s1_fix_r)               gtr_nxt = TR_FIX;
    else                             gtr_nxt = TR_NOFIX;

    itr_nxt = s1_imu_r ? TR_IMU_OK : TR_IMU_BAD;

    bad_nxt = !(enter_r > exit_r);
  end

  logic   s2_vld_r;
  score_t s2_gnss_r, s2_imu_r, s2_baro_r;
  trend_t s2_gtr_r, s2_itr_r;
  logic   s2_bad_r;
  tech_t  s2_cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    s2_gnss_r <= sc_gnss_nxt;
    s2_imu_r  <= sc_imu_nxt;
    s2_baro_r <= sc_baro_nxt;
    s2_gtr_r  <= gtr_nxt;
    s2_itr_r  <= itr_nxt;
    s2_bad_r  <= bad_nxt;
    s2_cur_r  <= s1_cur_r;
  end

  // ------------------------------------------------------------------
  // Stage 3: best-of-seven tree; zero-score techniques never win, so only
  // gnss, imu, mag and baro take part. Strict compares keep the low index.
  // ------------------------------------------------------------------
  tech_t  lo_tech, hi_tech, best_nxt;
  score_t lo_sc, hi_sc, bsc_nxt, cur_sc_nxt;

  always_comb begin
    if (s2_imu_r > s2_gnss_r) begin
      lo_tech = TECH_IMU;
      lo_sc   = s2_imu_r;
    end else begin
      lo_tech = TECH_GNSS;
      lo_sc   = s2_gnss_r;
    end

    if (s2_baro_r > SC_MAG) begin
      hi_tech = TECH_BARO;
      hi_sc   = s2_baro_r;
    end else begin
      hi_tech = TECH_MAG;
      hi_sc   = SC_MAG;
    end

    if (hi_sc > lo_sc) begin
      best_nxt = hi_tech;
      bsc_nxt  = hi_sc;
    end else begin
      best_nxt = lo_tech;
      bsc_nxt  = lo_sc;
    end

    // score of the technique currently selected
    unique case (s2_cur_r)
      TECH_GNSS: cur_sc_nxt = s2_gnss_r;
      TECH_IMU:  cur_sc_nxt = s2_imu_r;
      TECH_MAG:  cur_sc_nxt = SC_MAG;
      TECH_BARO: cur_sc_nxt = s2_baro_r;
      default:   cur_sc_nxt = SC_ZERO;
    endcase
  end

  logic   s3_vld_r;
  tech_t  s3_best_r, s3_cur_r;
  score_t s3_bsc_r, s3_cursc_r;
  trend_t s3_gtr_r, s3_itr_r;
  logic   s3_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    s3_best_r  <= best_nxt;
    s3_bsc_r   <= bsc_nxt;
    s3_cursc_r <= cur_sc_nxt;
    s3_cur_r   <= s2_cur_r;
    s3_gtr_r   <= s2_gtr_r;
    s3_itr_r   <= s2_itr_r;
    s3_bad_r   <= s2_bad_r;
  end

  // ------------------------------------------------------------------
  // Stage 4: bootstrap / hold / hysteresis decision
  // ------------------------------------------------------------------
  tech_t   sel_nxt, obest_nxt;
  score_t  obsc_nxt;
  logic    sw_nxt;
  reason_t rsn_nxt;

  always_comb begin
    sel_nxt   = s3_cur_r;
    obest_nxt = s3_best_r;
    obsc_nxt  = s3_bsc_r;
    sw_nxt    = 1'b0;
    if (s3_bad_r) begin
      obest_nxt = TECH_NONE;
      obsc_nxt  = SC_ZERO;
      rsn_nxt   = RSN_BADTH;
    end else if (s3_cur_r == TECH_NONE) begin
      if (s3_bsc_r >= enter_r) begin
        sel_nxt = s3_best_r;
        sw_nxt  = 1'b1;
        rsn_nxt = RSN_BOOT;
      end else begin
        rsn_nxt = RSN_BELOW;
      end
    end else if (s3_best_r == s3_cur_r) begin
      rsn_nxt = RSN_HOLDB;
    end else if (s3_bsc_r > enter_r && s3_cursc_r < exit_r) begin
      sel_nxt = s3_best_r;
      sw_nxt  = 1'b1;
      rsn_nxt = RSN_SWITCH;
    end else begin
      rsn_nxt = RSN_HOLD;
    end
  end

  logic    out_vld_r;
  tech_t   out_sel_r, out_best_r;
  score_t  out_bsc_r;
  logic    out_sw_r;
  reason_t out_rsn_r;
  trend_t  out_gtr_r, out_itr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    out_sel_r  <= sel_nxt;
    out_best_r <= obest_nxt;
    out_bsc_r  <= obsc_nxt;
    out_sw_r   <= sw_nxt;
    out_rsn_r  <= rsn_nxt;
    out_gtr_r  <= s3_gtr_r;
    out_itr_r  <= s3_itr_r;
  end

  assign out_valid              = out_vld_r;
  assign out_selected_technique = out_sel_r;
  assign out_best_technique     = out_best_r;
  assign out_best_score         = out_bsc_r;
  assign out_switched           = out_sw_r;
  assign out_reason_code        = out_rsn_r;
  assign out_gnss_trend         = out_gtr_r;
  assign out_imu_trend          = out_itr_r;

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  a_switch_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_switched == (out_reason_code == RSN_BOOT ||
                                    out_reason_code == RSN_SWITCH)))
    else $error("switch flag disagrees with reason");

  a_switch_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switched |-> out_selected_technique == out_best_technique)
    else $error("switched result does not select the best technique");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reason_code == RSN_BADTH |->
      out_best_technique == TECH_NONE && out_best_score == SC_ZERO)
    else $error("bad-threshold result carries a best technique");

  a_best_real: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reason_code != RSN_BADTH |->
      (out_best_technique == TECH_GNSS || out_best_technique == TECH_IMU ||
       out_best_technique == TECH_MAG  || out_best_technique == TECH_BARO))
    else $error("best technique is one that cannot score");

endmodule

`default_nettype wire

@@ tb/nav_technique_hysteresis_arbiter_test.sv @@
`default_nettype none

// Self-checking bench for the navigation technique arbiter.
// Reports go in as command transfers (start high, busy low at the edge); every
// accepted report predicts exactly one result, which is queued and compared
// against the next out_valid strobe. Threshold registers are only touched with
// nothing in flight.
module nav_technique_hysteresis_arbiter_test;
  import nthap_pkg::*;

  // one environment report as it crosses the input ports
  typedef struct packed {
    dom_t  domain;
    logic  outlier;
    logic  fix_ok;
    logic  recent;
    logic  imu_ok;
    tech_t current;
  } report_t;

  // one arbitration verdict as it leaves on the out_ ports
  typedef struct packed {
    tech_t   selected;
    tech_t   best;
    score_t  score;
    logic    switched;
    reason_t reason;
    trend_t  gnss_tr;
    trend_t  imu_tr;
  } verdict_t;

  localparam int MaxShown = 10;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [DomW-1:0]      in_domain = '0;
  logic                 in_gnss_outlier = 1'b0;
  logic                 in_gnss_fix_ok = 1'b0;
  logic                 in_gnss_recent_accept = 1'b0;
  logic                 in_imu_healthy = 1'b0;
  logic [TechW-1:0]     in_current_technique = '0;
  logic                 out_valid;
  logic [TechW-1:0]     out_selected_technique;
  logic [TechW-1:0]     out_best_technique;
  logic [ScoreW-1:0]    out_best_score;
  logic                 out_switched;
  logic [ReasonW-1:0]   out_reason_code;
  logic signed [TrendW-1:0] out_gnss_trend;
  logic signed [TrendW-1:0] out_imu_trend;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = CFG_ENTER;
  logic [ScoreW-1:0]    cfg_wdata = '0;

  // bench copy of the threshold registers, tracks every write
  score_t enter_thr = ENTER_RST;
  score_t exit_thr  = EXIT_RST;

  verdict_t pending_verdicts[$];
  int       reports_sent;
  int       verdicts_checked;
  int       mismatches;
  int       settings_used;
  int       reason_hits[8];
  bit       steady;   // when set the sender never idles between transfers

  nav_technique_hysteresis_arbiter u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_domain              (in_domain),
    .in_gnss_outlier        (in_gnss_outlier),
    .in_gnss_fix_ok         (in_gnss_fix_ok),
    .in_gnss_recent_accept  (in_gnss_recent_accept),
    .in_imu_healthy         (in_imu_healthy),
    .in_current_technique   (in_current_technique),
    .out_valid              (out_valid),
    .out_selected_technique (out_selected_technique),
    .out_best_technique     (out_best_technique),
    .out_best_score         (out_best_score),
    .out_switched           (out_switched),
    .out_reason_code        (out_reason_code),
    .out_gnss_trend         (out_gnss_trend),
    .out_imu_trend          (out_imu_trend),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor: scores all seven techniques, picks the best (strictly
  // greater wins, so ties stay with the lower index) and applies the
  // bootstrap / hold / hysteresis rules against the bench thresholds.
  // ---------------------------------------------------------------------
  function automatic verdict_t arbitrate(input report_t r);
    score_t   score_of [8];
    score_t   gnss_base;
    verdict_t v;
    case (r.domain)
      DOM_AIR, DOM_ROAD: gnss_base = 14'd9500;
      DOM_FLD:           gnss_base = 14'd7000;
      DOM_SEA:           gnss_base = 14'd8500;
      default:           gnss_base = SC_ZERO;
    endcase
    // gnss: no prior beats everything, then outlier, then fix, then recency
    if (gnss_base == SC_ZERO)  score_of[TECH_GNSS] = SC_ZERO;
    else if (r.outlier)        score_of[TECH_GNSS] = SC_GNSS_OUTL;
    else if (!r.fix_ok)        score_of[TECH_GNSS] = SC_ZERO;
    else if (!r.recent)        score_of[TECH_GNSS] = score_t'((32'(gnss_base) * 55) / 100);
    else                       score_of[TECH_GNSS] = gnss_base;
    // imu leans up when gnss is suspect
    if (!r.imu_ok)                   score_of[TECH_IMU] = SC_ZERO;
    else if (r.outlier || !r.fix_ok) score_of[TECH_IMU] = SC_IMU_NOFIX;
    else if (r.recent)               score_of[TECH_IMU] = SC_IMU_RCNT;
    else                             score_of[TECH_IMU] = SC_IMU_PLAIN;
    score_of[TECH_NONE] = SC_ZERO;
    score_of[TECH_CAM]  = SC_ZERO;
    score_of[TECH_LDR]  = SC_ZERO;
    score_of[TECH_ACU]  = SC_ZERO;
    score_of[TECH_MAG]  = SC_MAG;
    case (r.domain)
      DOM_AIR:          score_of[TECH_BARO] = 14'd2000;
      DOM_SEA, DOM_SUB: score_of[TECH_BARO] = 14'd2500;
      default:          score_of[TECH_BARO] = SC_ZERO;
    endcase

    if (r.outlier)                 v.gnss_tr = TR_OUTL;
    else if (r.fix_ok && r.recent) v.gnss_tr = TR_GOOD;
    else if (r.fix_ok)             v.gnss_tr = TR_FIX;
    else                           v.gnss_tr = TR_NOFIX;
    v.imu_tr = r.imu_ok ? TR_IMU_OK : TR_IMU_BAD;

    v.selected = r.current;
    v.best     = TECH_NONE;
    v.score    = SC_ZERO;
    v.switched = 1'b0;
    if (enter_thr <= exit_thr) begin
      // thresholds out of order: nothing is arbitrated
      v.reason = RSN_BADTH;
    end else begin
      v.best  = TECH_GNSS;
      v.score = score_of[TECH_GNSS];
      for (int k = 2; k < 8; k++) begin
        if (score_of[k] > v.score) begin
          v.score = score_of[k];
          v.best  = tech_t'(k);
        end
      end
      if (r.current == TECH_NONE) begin
        if (v.score >= enter_thr) begin
          v.selected = v.best;
          v.switched = 1'b1;
          v.reason   = RSN_BOOT;
        end else begin
          v.reason = RSN_BELOW;
        end
      end else if (v.best == r.current) begin
        v.reason = RSN_HOLDB;
      end else if (v.score > enter_thr && score_of[r.current] < exit_thr) begin
        v.selected = v.best;
        v.switched = 1'b1;
        v.reason   = RSN_SWITCH;
      end else begin
        v.reason = RSN_HOLD;
      end
    end
    return v;
  endfunction

  function automatic report_t make_report(input dom_t d, input logic outl, input logic fix,
                                          input logic rcnt, input logic imu, input tech_t cur);
    report_t r;
    r.domain  = d;
    r.outlier = outl;
    r.fix_ok  = fix;
    r.recent  = rcnt;
    r.imu_ok  = imu;
    r.current = cur;
    return r;
  endfunction

  function automatic report_t random_report();
    return make_report(dom_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), tech_t'($urandom_range(0, 7)));
  endfunction

  task automatic show_mismatch(input string what, input bit have_want,
                               input verdict_t want, input verdict_t seen);
    mismatches++;
    if (mismatches <= MaxShown) begin
      if (have_want)
        $display("%0t %s: exp sel=%0d best=%0d score=%0d sw=%0b rsn=%0d gtr=%0d itr=%0d",
                 $realtime, what, want.selected, want.best, want.score, want.switched,
                 want.reason, $signed(want.gnss_tr), $signed(want.imu_tr));
      $display("%0t %s: got sel=%0d best=%0d score=%0d sw=%0b rsn=%0d gtr=%0d itr=%0d",
               $realtime, what, seen.selected, seen.best, seen.score, seen.switched,
               seen.reason, $signed(seen.gnss_tr), $signed(seen.imu_tr));
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checker. The strobe marks the cycle ending at this edge, so the
  // ports are read before this edge's updates land.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    verdict_t seen;
    verdict_t want;
    if (rst_n && out_valid) begin
      seen.selected = out_selected_technique;
      seen.best     = out_best_technique;
      seen.score    = out_best_score;
      seen.switched = out_switched;
      seen.reason   = out_reason_code;
      seen.gnss_tr  = out_gnss_trend;
      seen.imu_tr   = out_imu_trend;
      if (pending_verdicts.size() == 0) begin
        show_mismatch("unexpected result", 1'b0, seen, seen);
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_checked++;
        if (seen !== want)
          show_mismatch("result mismatch", 1'b1, want, seen);
        else
          reason_hits[seen.reason]++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender. start is left high after a transfer; it only drops when an idle
  // gap follows, so back-to-back reports never see it toggle within a step.
  // ---------------------------------------------------------------------
  task automatic send_report(input report_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start                 <= 1'b1;
    in_domain             <= r.domain;
    in_gnss_outlier       <= r.outlier;
    in_gnss_fix_ok        <= r.fix_ok;
    in_gnss_recent_accept <= r.recent;
    in_imu_healthy        <= r.imu_ok;
    in_current_technique  <= r.current;
    do @(posedge clk); while (busy !== 1'b0);
    pending_verdicts.push_back(arbitrate(r));
    reports_sent++;
  endtask

  // hold the sender off until everything in flight has come back
  task automatic settle();
    int guard;
    start <= 1'b0;
    guard = 0;
    while (pending_verdicts.size() != 0 && guard < 200) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);   // pipeline is four deep
  endtask

  task automatic set_thresholds(input score_t enter_val, input score_t exit_val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENTER;
    cfg_wdata <= enter_val;
    @(posedge clk);
    enter_thr = enter_val;
    cfg_index <= CFG_EXIT;
    cfg_wdata <= exit_val;
    @(posedge clk);
    exit_thr = exit_val;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // every domain with a clean fix, starting from no selection
  task automatic test_domain_priors();
    for (int d = 0; d < 8; d++)
      send_report(make_report(dom_t'(d), 1'b0, 1'b1, 1'b1, 1'b1, TECH_NONE));
    // unknown domain with a dead imu: only mag scores, below enter
    send_report(make_report(dom_t'(5), 1'b0, 1'b0, 1'b0, 1'b0, TECH_NONE));
  endtask

  // gnss / imu flag combinations and each hysteresis outcome at reset levels
  task automatic test_flags_and_hysteresis();
    send_report(make_report(DOM_AIR,  1'b1, 1'b1, 1'b1, 1'b1, TECH_NONE));
    send_report(make_report(DOM_AIR,  1'b0, 1'b0, 1'b1, 1'b1, TECH_NONE));
    send_report(make_report(DOM_AIR,  1'b0, 1'b1, 1'b0, 1'b1, TECH_NONE));
    send_report(make_report(DOM_ROAD, 1'b0, 1'b1, 1'b0, 1'b0, TECH_NONE));
    send_report(make_report(DOM_AIR,  1'b0, 1'b1, 1'b1, 1'b1, TECH_GNSS));
    send_report(make_report(DOM_AIR,  1'b0, 1'b1, 1'b1, 1'b1, TECH_CAM));
    send_report(make_report(DOM_SUB,  1'b0, 1'b0, 1'b0, 1'b0, TECH_ACU));
    send_report(make_report(DOM_FLD,  1'b0, 1'b1, 1'b1, 1'b1, TECH_MAG));
    send_report(make_report(DOM_SEA,  1'b1, 1'b0, 1'b0, 1'b1, TECH_BARO));
    send_report(make_report(DOM_ROAD, 1'b0, 1'b1, 1'b1, 1'b1, TECH_IMU));
  endtask

  // register extremes, boundary equalities and thresholds out of order
  task automatic test_threshold_extremes();
    set_thresholds(14'h3FFF, 14'd0);
    send_report(make_report(DOM_AIR, 1'b0, 1'b1, 1'b1, 1'b1, TECH_NONE));
    send_report(make_report(DOM_AIR, 1'b0, 1'b1, 1'b1, 1'b1, TECH_LDR));
    set_thresholds(14'd1, 14'd0);
    send_report(make_report(dom_t'(6), 1'b0, 1'b0, 1'b0, 1'b0, TECH_NONE));
    // score equal to enter: bootstrap takes it, hysteresis does not
    set_thresholds(14'd9500, 14'd3000);
    send_report(make_report(DOM_AIR, 1'b0, 1'b1, 1'b1, 1'b1, TECH_NONE));
    send_report(make_report(DOM_AIR, 1'b0, 1'b1, 1'b1, 1'b1, TECH_CAM));
    // current score equal to exit is not below it
    set_thresholds(14'd9000, 14'd1500);
    send_report(make_report(DOM_AIR, 1'b0, 1'b1, 1'b1, 1'b1, TECH_MAG));
    set_thresholds(14'd5000, 14'd5000);
    send_report(make_report(DOM_SEA, 1'b0, 1'b1, 1'b1, 1'b0, TECH_GNSS));
    set_thresholds(14'd0, 14'h3FFF);
    send_report(make_report(DOM_AIR, 1'b1, 1'b1, 1'b1, 1'b1, TECH_NONE));
    set_thresholds(14'd0, 14'd0);
    send_report(make_report(DOM_ROAD, 1'b0, 1'b1, 1'b0, 1'b1, TECH_BARO));
  endtask

  // phases of random reports, each under its own threshold setting
  task automatic test_random_reports();
    score_t lo;
    score_t hi;
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 9))
        0: begin   // out of order
          hi = score_t'($urandom_range(0, 16383));
          lo = score_t'($urandom_range(0, hi));
          set_thresholds(lo, hi);
        end
        1: set_thresholds(14'h3FFF, 14'd0);
        2: set_thresholds(14'd1, 14'd0);
        3: set_thresholds(ENTER_RST, EXIT_RST);
        default: begin
          lo = score_t'($urandom_range(0, 9999));
          hi = score_t'($urandom_range(lo + 1, 10000));
          set_thresholds(hi, lo);
        end
      endcase
      steady = (phase % 3 == 1);
      for (int n = 0; n < 150; n++)
        send_report(random_report());
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_domain_priors();
    test_flags_and_hysteresis();
    test_threshold_extremes();
    test_random_reports();
    settle();
    if (pending_verdicts.size() != 0) begin
      $display("%0d results never arrived", pending_verdicts.size());
      mismatches += pending_verdicts.size();
    end
    $display("Covered %0d reports under %0d threshold settings, %0d results compared",
             reports_sent, settings_used, verdicts_checked);
    $display("Reasons: boot %0d below %0d holdbest %0d switch %0d hold %0d badthr %0d",
             reason_hits[RSN_BOOT], reason_hits[RSN_BELOW], reason_hits[RSN_HOLDB],
             reason_hits[RSN_SWITCH], reason_hits[RSN_HOLD], reason_hits[RSN_BADTH]);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/nthap_pkg.sv
rtl/nav_technique_hysteresis_arbiter.sv
tb/nav_technique_hysteresis_arbiter_test.sv
